/* src/bpa_pkg.sv */
`timescale 1ns / 1ps
// bpa_pkg: shared constants, types and address helpers of the buddy page allocator.
// No dependencies.
package bpa_pkg;

   localparam int NUM_PAGES  = 1024;
   localparam int MAX_ORDER  = 10;
   localparam int PAGE_SHIFT = 12;
   localparam int NUM_ORDERS = MAX_ORDER + 1;
   localparam int PAGE_W     = 10;
   localparam int ORDER_W    = 4;
   localparam int SIZE_W     = 23;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int FM_DEPTH   = 68;   // free-map words over all orders
   localparam int FM_ADDR_W  = 7;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
   localparam logic [1:0] ST_BAD_FREE  = 2'd3;

   typedef struct packed {
      logic                 op;
      logic                 too_large;
      logic [ORDER_W-1:0]   want;
      logic [PAGE_W-1:0]    page;
   } item_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_PICK, S_SPLIT_RD, S_SPLIT_WR, S_HEAD_WR,
      S_F_CHK, S_M_RD, S_M_CHK, S_FIN_WR, S_EMIT
   } state_type;

   // First word of order k in the free-map memory.
   function automatic logic [FM_ADDR_W-1:0] word_base(input logic [ORDER_W-1:0] k);
      int acc;
      int w;
      acc = 0;
      for (int j = 0; j < NUM_ORDERS; j++) begin
         w = (NUM_PAGES >> j) / WORD_W;
         if (w < 1) w = 1;
         if (j < int'(k)) acc = acc + w;
      end
      return FM_ADDR_W'(acc);
   endfunction

   function automatic logic [FM_ADDR_W-1:0] fm_addr(input logic [ORDER_W-1:0] k,
                                                    input logic [PAGE_W-1:0] page);
      logic [PAGE_W-1:0] b;
      b = page >> k;
      return word_base(k) + FM_ADDR_W'(b >> BIT_W);
   endfunction

   function automatic logic [BIT_W-1:0] fm_widx(input logic [ORDER_W-1:0] k,
                                                input logic [PAGE_W-1:0] page);
      logic [PAGE_W-1:0] b;
      b = page >> k;
      return b[PAGE_W-1:BIT_W];
   endfunction

   function automatic logic [BIT_W-1:0] fm_bit(input logic [ORDER_W-1:0] k,
                                               input logic [PAGE_W-1:0] page);
      logic [PAGE_W-1:0] b;
      b = page >> k;
      return b[BIT_W-1:0];
   endfunction

   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

endpackage

/* src/buddy_page_allocator.sv */
`timescale 1ns / 1ps
// buddy_page_allocator: top level, binary buddy allocator over 1024 pages, orders 0..10.
// Depends on bpa_pkg, bpa_front, bpa_back.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | opcode, size_bytes, page_index
//   rsp     | out       | rsp_valid/rsp_ready   | status, block_page, block_order
//
// Allocate walks the split levels and free walks the merge levels one at a time,
// each level being one free-map read-modify-write.
// One item is worked on at a time by the back sequencer.
// After reset a clearing pass runs over the head and free-map
// memories; requests are queued meanwhile (two-entry queue) but not processed.
// A stalled result holds in the back end; the front takes items until its queue is full.
module buddy_page_allocator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_opcode,
   input  logic [22:0]  req_size_bytes,
   input  logic [9:0]   req_page_index,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [9:0]   rsp_block_page,
   output logic [3:0]   rsp_block_order
);

   logic              q_valid;
   logic              q_pop;
   bpa_pkg::item_type q_item;

   // front: size to order, two-entry queue
   bpa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_size_bytes (req_size_bytes),
      .req_page_index (req_page_index),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // back: split / merge sequencer with the bitmaps and head table
   bpa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_block_page  (rsp_block_page),
      .rsp_block_order (rsp_block_order)
   );

   // error results carry no block
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bpa_pkg::ST_OK) |->
         (rsp_block_page == 10'd0 && rsp_block_order == 4'd0))
      else $error("error result with nonzero block");

   // a good result never exceeds the top order
   a_ord_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bpa_pkg::ST_OK) |->
         (rsp_block_order <= 4'(bpa_pkg::MAX_ORDER)))
      else $error("order beyond top order");

   // block head is aligned to its order
   a_align: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bpa_pkg::ST_OK) |->
         ((rsp_block_page & ~(10'h3FF << rsp_block_order)) == 10'd0))
      else $error("misaligned block head");

endmodule

/* src/bpa_front.sv */
`timescale 1ns / 1ps
// bpa_front: accepts requests, turns the byte size into an order, queues items.
// Depends on bpa_pkg.
module bpa_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [bpa_pkg::SIZE_W-1:0]  req_size_bytes,
   input  logic [bpa_pkg::PAGE_W-1:0]  req_page_index,
   output logic                        q_valid,
   output bpa_pkg::item_type           q_item,
   input  logic                        q_pop
);

   localparam int PG_W = bpa_pkg::SIZE_W - bpa_pkg::PAGE_SHIFT + 1;

   bpa_pkg::item_type        q_ff [2];
   bpa_pkg::item_type        item;
   logic                     wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [PG_W-1:0]          pages, pm1;
   logic [4:0]               want;
   logic                     push;

   always_comb begin
      pages = PG_W'(({1'b0, req_size_bytes} + 24'((1 << bpa_pkg::PAGE_SHIFT) - 1))
                    >> bpa_pkg::PAGE_SHIFT);
      pm1   = pages - PG_W'(1);
      want  = '0;
      if (pages > PG_W'(1)) begin
         for (int i = 0; i < PG_W; i++) begin
            if (pm1[i]) want = 5'(i + 1);
         end
      end
      item.op        = req_opcode;
      item.too_large = (want > 5'(bpa_pkg::MAX_ORDER));
      item.want      = want[bpa_pkg::ORDER_W-1:0];
      item.page      = req_page_index;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= item;
   end

endmodule

/* src/bpa_back.sv */
`timescale 1ns / 1ps
// bpa_back: sequencer that carries out allocate and free on the free-map and head memories.
// Depends on bpa_pkg.
module bpa_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  bpa_pkg::item_type            q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_block_page,
   output logic [bpa_pkg::ORDER_W-1:0]  rsp_block_order
);

   localparam int PW = bpa_pkg::PAGE_W;
   localparam int OW = bpa_pkg::ORDER_W;
   localparam int AW = bpa_pkg::FM_ADDR_W;
   localparam int WW = bpa_pkg::WORD_W;
   localparam int NO = bpa_pkg::NUM_ORDERS;

   // summary after reset: only word 0 of the top order holds a free block
   localparam logic [NO-1:0][WW-1:0] SUM_RST = (NO*WW)'(1) << (bpa_pkg::MAX_ORDER * WW);

   logic [WW-1:0]     fmem [bpa_pkg::FM_DEPTH];
   logic [OW:0]       hmem [bpa_pkg::NUM_PAGES];

   bpa_pkg::state_type state_ff, state_in;
   logic [PW-1:0]     clr_ff, clr_in;
   logic [PW-1:0]     page_ff, page_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [OW-1:0]     want_ff, want_in;
   logic [4:0]        widx_ff, widx_in;
   logic [1:0]        st_ff, st_in;
   logic [NO-1:0][WW-1:0] sum_ff;

   logic [WW-1:0]     frd_ff;
   logic [OW:0]       hrd_ff;
   logic [AW-1:0]     fraddr, fwaddr;
   logic [WW-1:0]     fwdata;
   logic              fwe;
   logic [PW-1:0]     hraddr, hwaddr;
   logic [OW:0]       hwdata;
   logic              hwe;
   logic              sum_we, sum_v;
   logic [OW-1:0]     sum_k;
   logic [4:0]        sum_w;

   logic [OW-1:0]     fk, lvl;
   logic              found;
   logic [PW-1:0]     blk, tgt, buddy;
   logic [4:0]        bsel;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      page_in  = page_ff;
      ord_in   = ord_ff;
      want_in  = want_ff;
      widx_in  = widx_ff;
      st_in    = st_ff;
      q_pop    = 1'b0;
      fraddr   = '0;
      fwaddr   = '0;
      fwdata   = '0;
      fwe      = 1'b0;
      hraddr   = '0;
      hwaddr   = '0;
      hwdata   = '0;
      hwe      = 1'b0;
      sum_we   = 1'b0;
      sum_v    = 1'b0;
      sum_k    = '0;
      sum_w    = '0;
      found    = 1'b0;
      fk       = '0;
      lvl      = ord_ff - OW'(1);
      blk      = '0;
      tgt      = page_ff + (PW'(1) << lvl);
      buddy    = page_ff ^ (PW'(1) << ord_ff);
      bsel     = '0;
      for (int k = NO - 1; k >= 0; k--) begin
         if (OW'(k) >= q_item.want && |sum_ff[k]) begin
            found = 1'b1;
            fk    = OW'(k);
         end
      end
      unique case (state_ff)
         bpa_pkg::S_CLEAR: begin
            hwe    = 1'b1;
            hwaddr = clr_ff;
            if (clr_ff < PW'(bpa_pkg::FM_DEPTH)) begin
               fwe    = 1'b1;
               fwaddr = clr_ff[AW-1:0];
               fwdata = (clr_ff[AW-1:0] == bpa_pkg::word_base(OW'(bpa_pkg::MAX_ORDER)))
                        ? WW'(1) : '0;
            end
            clr_in = clr_ff + PW'(1);
            if (clr_ff == PW'(bpa_pkg::NUM_PAGES - 1)) state_in = bpa_pkg::S_IDLE;
         end
         bpa_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               want_in = q_item.want;
               page_in = q_item.page;
               if (q_item.op == bpa_pkg::OP_FREE) begin
                  hraddr   = q_item.page;
                  state_in = bpa_pkg::S_F_CHK;
               end else if (q_item.too_large) begin
                  st_in    = bpa_pkg::ST_TOO_LARGE;
                  page_in  = '0;
                  ord_in   = '0;
                  state_in = bpa_pkg::S_EMIT;
               end else if (!found) begin
                  st_in    = bpa_pkg::ST_NO_BLOCK;
                  page_in  = '0;
                  ord_in   = '0;
                  state_in = bpa_pkg::S_EMIT;
               end else begin
                  ord_in   = fk;
                  widx_in  = bpa_pkg::first_set(sum_ff[fk]);
                  fraddr   = bpa_pkg::word_base(fk) + AW'(bpa_pkg::first_set(sum_ff[fk]));
                  state_in = bpa_pkg::S_A_PICK;
               end
            end
         end
         bpa_pkg::S_A_PICK: begin
            // take lowest free block of the found order and mark it used
            bsel    = bpa_pkg::first_set(frd_ff);
            blk     = {widx_ff, bsel};
            page_in = blk << ord_ff;
            fwe     = 1'b1;
            fwaddr  = bpa_pkg::word_base(ord_ff) + AW'(widx_ff);
            fwdata  = frd_ff & ~(WW'(1) << bsel);
            sum_we  = 1'b1;
            sum_k   = ord_ff;
            sum_w   = widx_ff;
            sum_v   = |fwdata;
            state_in = (ord_ff > want_ff) ? bpa_pkg::S_SPLIT_RD : bpa_pkg::S_HEAD_WR;
         end
         bpa_pkg::S_SPLIT_RD: begin
            fraddr   = bpa_pkg::fm_addr(lvl, tgt);
            state_in = bpa_pkg::S_SPLIT_WR;
         end
         bpa_pkg::S_SPLIT_WR: begin
            // upper half of the split goes back free at the next lower order
            fwe     = 1'b1;
            fwaddr  = bpa_pkg::fm_addr(lvl, tgt);
            fwdata  = frd_ff | (WW'(1) << bpa_pkg::fm_bit(lvl, tgt));
            sum_we  = 1'b1;
            sum_k   = lvl;
            sum_w   = bpa_pkg::fm_widx(lvl, tgt);
            sum_v   = 1'b1;
            ord_in  = lvl;
            state_in = (lvl > want_ff) ? bpa_pkg::S_SPLIT_RD : bpa_pkg::S_HEAD_WR;
         end
         bpa_pkg::S_HEAD_WR: begin
            hwe      = 1'b1;
            hwaddr   = page_ff;
            hwdata   = {1'b1, want_ff};
            ord_in   = want_ff;
            st_in    = bpa_pkg::ST_OK;
            state_in = bpa_pkg::S_EMIT;
         end
         bpa_pkg::S_F_CHK: begin
            if (!hrd_ff[OW]) begin
               st_in    = bpa_pkg::ST_BAD_FREE;
               page_in  = '0;
               ord_in   = '0;
               state_in = bpa_pkg::S_EMIT;
            end else begin
               ord_in   = hrd_ff[OW-1:0];
               hwe      = 1'b1;
               hwaddr   = page_ff;
               hwdata   = {1'b0, hrd_ff[OW-1:0]};
               state_in = bpa_pkg::S_M_RD;
            end
         end
         bpa_pkg::S_M_RD: begin
            if (ord_ff >= OW'(bpa_pkg::MAX_ORDER)) begin
               fraddr   = bpa_pkg::fm_addr(ord_ff, page_ff);
               state_in = bpa_pkg::S_FIN_WR;
            end else begin
               fraddr   = bpa_pkg::fm_addr(ord_ff, buddy);
               state_in = bpa_pkg::S_M_CHK;
            end
         end
         bpa_pkg::S_M_CHK: begin
            if (frd_ff[bpa_pkg::fm_bit(ord_ff, buddy)]) begin
               // buddy free: take it out and climb one order
               fwe      = 1'b1;
               fwaddr   = bpa_pkg::fm_addr(ord_ff, buddy);
               fwdata   = frd_ff & ~(WW'(1) << bpa_pkg::fm_bit(ord_ff, buddy));
               sum_we   = 1'b1;
               sum_k    = ord_ff;
               sum_w    = bpa_pkg::fm_widx(ord_ff, buddy);
               sum_v    = |fwdata;
               page_in  = page_ff & ~(PW'(1) << ord_ff);
               ord_in   = ord_ff + OW'(1);
               state_in = bpa_pkg::S_M_RD;
            end else begin
               fraddr   = bpa_pkg::fm_addr(ord_ff, page_ff);
               state_in = bpa_pkg::S_FIN_WR;
            end
         end
         bpa_pkg::S_FIN_WR: begin
            fwe      = 1'b1;
            fwaddr   = bpa_pkg::fm_addr(ord_ff, page_ff);
            fwdata   = frd_ff | (WW'(1) << bpa_pkg::fm_bit(ord_ff, page_ff));
            sum_we   = 1'b1;
            sum_k    = ord_ff;
            sum_w    = bpa_pkg::fm_widx(ord_ff, page_ff);
            sum_v    = 1'b1;
            st_in    = bpa_pkg::ST_OK;
            state_in = bpa_pkg::S_EMIT;
         end
         bpa_pkg::S_EMIT: begin
            if (rsp_ready) state_in = bpa_pkg::S_IDLE;
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_CLEAR;
         clr_ff   <= '0;
         sum_ff   <= SUM_RST;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (sum_we) sum_ff[sum_k][sum_w] <= sum_v;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      ord_ff  <= ord_in;
      want_ff <= want_in;
      widx_ff <= widx_in;
      st_ff   <= st_in;
   end

   always_ff @(posedge clock) begin
      if (fwe) fmem[fwaddr] <= fwdata;
      frd_ff <= fmem[fraddr];
   end

   always_ff @(posedge clock) begin
      if (hwe) hmem[hwaddr] <= hwdata;
      hrd_ff <= hmem[hraddr];
   end

   assign rsp_valid       = (state_ff == bpa_pkg::S_EMIT);
   assign rsp_status      = st_ff;
   assign rsp_block_page  = page_ff;
   assign rsp_block_order = ord_ff;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for buddy_page_allocator; random allocate/free traffic
// against an in-bench buddy allocator predictor. Depends on bpa_pkg and the DUT.

// Predicts allocator results and holds them until the block returns them.
class buddy_scoreboard;
   bit                      fmap [bpa_pkg::MAX_ORDER+1][bpa_pkg::NUM_PAGES];
   logic [3:0]              blk_order [bpa_pkg::NUM_PAGES];
   bit                      blk_used [bpa_pkg::NUM_PAGES];
   logic [1:0]              want_status [$];
   logic [9:0]              want_page [$];
   logic [3:0]              want_order [$];
   int                      errors;

   function new();
      foreach (fmap[k, p]) fmap[k][p] = 0;
      foreach (blk_used[p]) begin
         blk_used[p] = 0;
         blk_order[p] = '0;
      end
      fmap[bpa_pkg::MAX_ORDER][0] = 1;
      errors = 0;
   endfunction

   function int pending();
      return want_status.size();
   endfunction

   function void push(logic [1:0] st, logic [9:0] pg, logic [3:0] od);
      want_status.push_back(st);
      want_page.push_back(pg);
      want_order.push_back(od);
   endfunction

   // fmap[k][b] indexed by block number within order k
   function void note_request(logic op, logic [22:0] size, logic [9:0] pidx);
      int pages, want, k, b, fk, base, o, bud, pg;
      bit found;
      if (op == bpa_pkg::OP_ALLOC) begin
         pages = (int'(size) + 4095) >> bpa_pkg::PAGE_SHIFT;
         want = 0;
         while (want <= bpa_pkg::MAX_ORDER && (1 << want) < pages) want++;
         if (want > bpa_pkg::MAX_ORDER) begin
            push(bpa_pkg::ST_TOO_LARGE, '0, '0);
            return;
         end
         found = 0;
         fk = 0;
         base = 0;
         for (k = want; k <= bpa_pkg::MAX_ORDER && !found; k++)
            for (b = 0; b < (bpa_pkg::NUM_PAGES >> k); b++)
               if (fmap[k][b]) begin
                  found = 1;
                  fk = k;
                  base = b << k;
                  break;
               end
         if (!found) begin
            push(bpa_pkg::ST_NO_BLOCK, '0, '0);
            return;
         end
         fmap[fk][base >> fk] = 0;
         for (k = fk; k > want; k--)
            fmap[k-1][(base + (1 << (k-1))) >> (k-1)] = 1;
         blk_used[base] = 1;
         blk_order[base] = want[3:0];
         push(bpa_pkg::ST_OK, base[9:0], want[3:0]);
      end else begin
         pg = pidx;
         if (!blk_used[pg]) begin
            push(bpa_pkg::ST_BAD_FREE, '0, '0);
            return;
         end
         o = blk_order[pg];
         blk_used[pg] = 0;
         while (o < bpa_pkg::MAX_ORDER) begin
            bud = pg ^ (1 << o);
            if (!fmap[o][bud >> o]) break;
            fmap[o][bud >> o] = 0;
            if (bud < pg) pg = bud;
            o++;
         end
         fmap[o][pg >> o] = 1;
         push(bpa_pkg::ST_OK, pg[9:0], o[3:0]);
      end
   endfunction

   task report(string what, int got, int exp);
      $display("ERROR %0s got %0d expected %0d at %0t", what, got, exp, $time);
      errors++;
   endtask

   task check_result(logic [1:0] st, logic [9:0] pg, logic [3:0] od);
      logic [1:0] es;
      logic [9:0] ep;
      logic [3:0] eo;
      if (want_status.size() == 0) begin
         report("unexpected result status", st, -1);
         return;
      end
      es = want_status.pop_front();
      ep = want_page.pop_front();
      eo = want_order.pop_front();
      if (st !== es) report("status", st, es);
      if (pg !== ep) report("block_page", pg, ep);
      if (od !== eo) report("block_order", od, eo);
   endtask
endclass

module tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [22:0] req_size_bytes;
   logic [9:0]  req_page_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_block_page;
   logic [3:0]  rsp_block_order;

   buddy_scoreboard sb;
   int  cycle;
   bit  calm;                 // last part of run: no idling
   logic [9:0] live [$];      // heads we believe are allocated (for well-formed frees)

   localparam int CYCLE_LIMIT = 400000;

   buddy_page_allocator DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > CYCLE_LIMIT) begin
         $display("buddy_page_allocator: mismatch");
         $finish;
      end
   end

   // result side: sample at rising edge, change ready on falling edge
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_block_page, rsp_block_order);

   initial begin
      int n;
      rsp_ready = 0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            n = $urandom_range(1, 5);
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1;
         @(negedge clock);
      end
   end

   // Drive one item and wait for its acceptance; prediction happens on accept.
   task automatic send_item(logic op, logic [22:0] size, logic [9:0] pidx);
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 5);
         repeat (n) @(negedge clock);
      end
      req_valid = 1;
      req_opcode = op;
      req_size_bytes = size;
      req_page_index = pidx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, size, pidx);
      if (op == bpa_pkg::OP_ALLOC && sb.want_status[$] == bpa_pkg::ST_OK)
         live.push_back(sb.want_page[$]);
      if (op == bpa_pkg::OP_FREE && sb.want_status[$] == bpa_pkg::ST_OK)
         foreach (live[i]) if (live[i] == pidx) begin
            live.delete(i);
            break;
         end
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_alloc(logic [22:0] size);
      send_item(bpa_pkg::OP_ALLOC, size, 10'($urandom));
   endtask

   task automatic send_free(logic [9:0] pidx);
      send_item(bpa_pkg::OP_FREE, 23'($urandom), pidx);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Mostly small sizes so the map fills and fragments; sometimes any size.
   function automatic logic [22:0] rand_size();
      int o;
      case ($urandom_range(0, 9))
         0: return 23'($urandom);
         1: return 23'($urandom_range(0, 4194304));
         default: begin
            o = $urandom_range(0, 4);
            return 23'($urandom_range((1 << o) * 4096 - 4095, (1 << o) * 4096));
         end
      endcase
   endfunction

   initial begin
      int idx;
      sb = new();
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_opcode = bpa_pkg::OP_ALLOC;
      req_size_bytes = '0;
      req_page_index = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: size extremes, rounding edges, bad frees, merges
      send_alloc(23'd4194304);          // whole memory, order 10
      send_alloc(23'd0);                // exhausted
      send_free(10'd0);                 // freed at the top order
      send_free(10'd0);                 // bad free, already free
      send_alloc(23'd4194305);          // too large
      send_alloc(23'h7FFFFF);           // too large, all ones
      send_alloc(23'd0);                // zero size, order 0
      send_alloc(23'd4096);             // order 0
      send_alloc(23'd4097);             // rounds up to order 1
      send_alloc(23'd8192);
      send_alloc(23'd8193);             // order 2
      send_free(10'd1023);              // bad free, never allocated
      send_free(10'd1);                 // head of order-0 block
      send_free(10'd3);                 // not a head
      send_free(10'd0);
      send_free(10'd2);
      send_free(10'd4);                 // merges up to order 3; page 8 is still held
      send_alloc(23'd2097152);          // order 9
      send_alloc(23'd2097153);          // order 10: none left
      send_alloc(23'd2097152);
      send_free(10'd512);
      send_free(10'd0);
      drain();                          // sender holds off until all results are back
      live.delete();

      for (int i = 0; i < 1030; i++) begin
         if (i == 850) calm = 1;
         if (live.size() > 0 && $urandom_range(0, 99) < 45) begin
            idx = $urandom_range(0, live.size() - 1);
            send_free(live[idx]);
         end else if ($urandom_range(0, 19) == 0)
            send_free(10'($urandom));   // noise: mostly bad frees
         else
            send_alloc(rand_size());
      end

      drain();
      repeat (60) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("buddy_page_allocator: match");
      else
         $display("buddy_page_allocator: mismatch");
      $finish;
   end
endmodule
